// ===== hdl/hsv2rgb_pkg.sv =====
// Package with the pixel types, hue constants and sector codes of the HSV to RGB converter.
package hsv2rgb_pkg;

  localparam int unsigned HueW     = 15;
  localparam int unsigned LevelW   = 9;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned WeightW  = 12;
  localparam int unsigned SvProdW  = 18;
  localparam int unsigned SvW      = 26;
  localparam int unsigned QuotW    = 14;
  localparam int unsigned RecipW   = 16;
  localparam int unsigned RecipSh  = 19;

  localparam logic [HueW-1:0]   HueSector   = 15'd3840;
  localparam logic [HueW-1:0]   HueTwoSect  = 15'd7680;
  localparam logic [HueW-1:0]   HueThreeSct = 15'd11520;
  localparam logic [HueW-1:0]   HueFourSect = 15'd15360;
  localparam logic [HueW-1:0]   HueFiveSect = 15'd19200;
  localparam logic [HueW-1:0]   HueFullTurn = 15'd23040;
  localparam logic [RecipW-1:0] RecipFifteen = 16'd34953;
  localparam logic [ByteW-1:0]  ByteMax     = 8'd255;

  typedef enum logic [2:0] {
    SECT_RED_YEL  = 3'd0,
    SECT_YEL_GRN  = 3'd1,
    SECT_GRN_CYAN = 3'd2,
    SECT_CYAN_BLU = 3'd3,
    SECT_BLU_MAG  = 3'd4,
    SECT_MAG_RED  = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HueW-1:0]   hue;
    logic [LevelW-1:0] saturation;
    logic [LevelW-1:0] brightness;
    logic [ByteW-1:0]  alpha_in;
  } hsv_pixel_t;

  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] alpha_out;
  } rgb_pixel_t;

  typedef struct packed {
    sector_e            sector;
    logic [WeightW-1:0] weight;
    logic               black;
  } hue_info_t;

endpackage

// ===== hdl/hsv2rgb_hue_map.sv =====
// Hue decoder that finds the sixty-degree sector, the partial-level weight and the black case.
module hsv2rgb_hue_map
  import hsv2rgb_pkg::*;
(
  input  logic [HueW-1:0] hue_i,
  output hue_info_t       info_o
);

  logic [HueW-1:0] hue_mod;
  sector_e         sector;

  always_comb begin
    if (hue_i >= HueFourSect) begin
      hue_mod = hue_i - HueFourSect;
    end else if (hue_i >= HueTwoSect) begin
      hue_mod = hue_i - HueTwoSect;
    end else begin
      hue_mod = hue_i;
    end
  end

  always_comb begin
    if (hue_i >= HueFiveSect) begin
      sector = SECT_MAG_RED;
    end else if (hue_i >= HueFourSect) begin
      sector = SECT_BLU_MAG;
    end else if (hue_i >= HueThreeSct) begin
      sector = SECT_CYAN_BLU;
    end else if (hue_i >= HueTwoSect) begin
      sector = SECT_GRN_CYAN;
    end else if (hue_i >= HueSector) begin
      sector = SECT_YEL_GRN;
    end else begin
      sector = SECT_RED_YEL;
    end
  end

  logic [HueW-1:0] weight_full;

  always_comb begin
    if (hue_mod >= HueSector) begin
      weight_full = HueTwoSect - hue_mod;
    end else begin
      weight_full = hue_mod;
    end
  end

  assign info_o.sector = sector;
  assign info_o.weight = weight_full[WeightW-1:0];
  assign info_o.black  = (hue_i >= HueFullTurn);

endmodule

// ===== hdl/hsv_to_rgb_converter.sv =====
// Top level of the pipelined HSV to RGB pixel converter.
//
// One item is an HSV pixel with alpha on pixel_i, taken at a rising edge where
// start_i is high and busy_o is low. busy_o is always low, so an item may be
// given in every cycle and the throughput is one item per clock.
// The result appears on result_o from the output select register and is
// marked by done_o for exactly one cycle; results leave in the order of entry.
// The five stages are the saturation-brightness product, the scaling by 255
// with the full level, the product with the hue weight, the reciprocal
// multiply that divides by fifteen, and the output select register.
// The receiver cannot hold results off, and the pipeline never waits.
// Reset clears all valid bits, so no result appears until an item is given.
// A hue of 360 degrees or more gives black with alpha passed through.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  hsv_pixel_t pixel_i,
  output logic       busy_o,
  output logic       done_o,
  output rgb_pixel_t result_o
);

  hue_info_t hue_info;

  hsv2rgb_hue_map u_hue_map (
    .hue_i  (pixel_i.hue),
    .info_o (hue_info)
  );

  assign busy_o = 1'b0;

  logic [4:0] valid_q;
  logic       accept;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[3:0], accept};
    end
  end

  logic [SvProdW-1:0] s1_prod_q;
  hue_info_t          s1_info_q;
  logic [ByteW-1:0]   s1_alpha_q;

  always_ff @(posedge clk_i) begin
    s1_prod_q  <= SvProdW'(pixel_i.saturation) * SvProdW'(pixel_i.brightness);
    s1_info_q  <= hue_info;
    s1_alpha_q <= pixel_i.alpha_in;
  end

  logic [SvW-1:0]   sv_d;
  logic [ByteW-1:0] full_d;
  assign sv_d = {s1_prod_q, 8'd0} - SvW'(s1_prod_q);

  always_comb begin
    if (sv_d[SvW-1:16] > (SvW-16)'(ByteMax)) begin
      full_d = ByteMax;
    end else begin
      full_d = sv_d[16 +: ByteW];
    end
  end

  logic [SvW-1:0]   s2_sv_q;
  logic [ByteW-1:0] s2_full_q;
  hue_info_t        s2_info_q;
  logic [ByteW-1:0] s2_alpha_q;

  always_ff @(posedge clk_i) begin
    s2_sv_q    <= sv_d;
    s2_full_q  <= full_d;
    s2_info_q  <= s1_info_q;
    s2_alpha_q <= s1_alpha_q;
  end

  logic [SvW+WeightW-1:0] sw_prod;
  assign sw_prod = (SvW+WeightW)'(s2_sv_q) * (SvW+WeightW)'(s2_info_q.weight);

  logic [QuotW-1:0] s3_quot_q;
  logic [ByteW-1:0] s3_full_q;
  hue_info_t        s3_info_q;
  logic [ByteW-1:0] s3_alpha_q;

  always_ff @(posedge clk_i) begin
    s3_quot_q  <= sw_prod[24 +: QuotW];
    s3_full_q  <= s2_full_q;
    s3_info_q  <= s2_info_q;
    s3_alpha_q <= s2_alpha_q;
  end

  logic [QuotW+RecipW-1:0] recip_prod;
  logic [ByteW-1:0]        part_d;
  assign recip_prod = (QuotW+RecipW)'(s3_quot_q) * (QuotW+RecipW)'(RecipFifteen);

  always_comb begin
    if (recip_prod[QuotW+RecipW-1:RecipSh+ByteW] != '0) begin
      part_d = ByteMax;
    end else begin
      part_d = recip_prod[RecipSh +: ByteW];
    end
  end

  logic [ByteW-1:0] s4_part_q;
  logic [ByteW-1:0] s4_full_q;
  hue_info_t        s4_info_q;
  logic [ByteW-1:0] s4_alpha_q;

  always_ff @(posedge clk_i) begin
    s4_part_q  <= part_d;
    s4_full_q  <= s3_full_q;
    s4_info_q  <= s3_info_q;
    s4_alpha_q <= s3_alpha_q;
  end

  rgb_pixel_t out_d;
  rgb_pixel_t out_q;
  logic       out_black_q;

  always_comb begin
    out_d.alpha_out = s4_alpha_q;
    out_d.red       = '0;
    out_d.green     = '0;
    out_d.blue      = '0;
    if (!s4_info_q.black) begin
      case (s4_info_q.sector)
        SECT_RED_YEL: begin
          out_d.red   = s4_full_q;
          out_d.green = s4_part_q;
        end
        SECT_YEL_GRN: begin
          out_d.red   = s4_part_q;
          out_d.green = s4_full_q;
        end
        SECT_GRN_CYAN: begin
          out_d.green = s4_full_q;
          out_d.blue  = s4_part_q;
        end
        SECT_CYAN_BLU: begin
          out_d.green = s4_part_q;
          out_d.blue  = s4_full_q;
        end
        SECT_BLU_MAG: begin
          out_d.red  = s4_part_q;
          out_d.blue = s4_full_q;
        end
        default: begin
          out_d.red  = s4_full_q;
          out_d.blue = s4_part_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    out_black_q <= s4_info_q.black;
  end

  assign done_o   = valid_q[4];
  assign result_o = out_q;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("Converter reported busy.");

  a_valid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |=> valid_q[2])
    else $error("Valid bit lost inside the pipeline.");

  a_part_le_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[3] && !s4_info_q.black) |-> (s4_part_q <= s4_full_q))
    else $error("Partial level exceeds full level.");

  a_black_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_black_q) |-> (result_o.red == '0 && result_o.green == '0 &&
                                 result_o.blue == '0))
    else $error("Out-of-range hue did not give black.");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the HSV to RGB pixel converter.
`timescale 1ns / 1ps

module testbench
  import hsv2rgb_pkg::*;
();

  class pixel_checker;
    rgb_pixel_t  rgb_pending_q[$];
    int unsigned pixels_in;
    int unsigned results_seen;
    int unsigned black_pixels;
    int unsigned clamped_pixels;
    int unsigned failures;

    function new();
      pixels_in      = 0;
      results_seen   = 0;
      black_pixels   = 0;
      clamped_pixels = 0;
      failures       = 0;
    endfunction

    function longint unsigned clamp_level(input longint unsigned lvl);
      return (lvl > ByteMax) ? longint'(ByteMax) : lvl;
    endfunction

    function rgb_pixel_t hsv_to_rgb_levels(input hsv_pixel_t p);
      rgb_pixel_t      o;
      longint unsigned sv;
      longint unsigned hm;
      longint unsigned hue_dist;
      longint unsigned w;
      longint unsigned full_lvl;
      longint unsigned part_lvl;
      sector_e         sect;
      o           = '0;
      o.alpha_out = p.alpha_in;
      if (p.hue < HueFullTurn) begin
        sv       = longint'(ByteMax) * 64'(p.saturation) * 64'(p.brightness);
        hm       = 64'(p.hue) % 64'(HueTwoSect);
        hue_dist = (hm >= HueSector) ? hm - HueSector : HueSector - hm;
        w        = 64'(HueSector) - hue_dist;
        full_lvl = clamp_level(sv / 65536);
        part_lvl = clamp_level((sv * w) / (65536 * 64'(HueSector)));
        sect     = sector_e'(3'(p.hue / HueSector));
        case (sect)
          SECT_RED_YEL: begin
            o.red = 8'(full_lvl); o.green = 8'(part_lvl);
          end
          SECT_YEL_GRN: begin
            o.red = 8'(part_lvl); o.green = 8'(full_lvl);
          end
          SECT_GRN_CYAN: begin
            o.green = 8'(full_lvl); o.blue = 8'(part_lvl);
          end
          SECT_CYAN_BLU: begin
            o.green = 8'(part_lvl); o.blue = 8'(full_lvl);
          end
          SECT_BLU_MAG: begin
            o.red = 8'(part_lvl); o.blue = 8'(full_lvl);
          end
          default: begin
            o.red = 8'(full_lvl); o.blue = 8'(part_lvl);
          end
        endcase
      end
      return o;
    endfunction

    function void note_pixel(input hsv_pixel_t p);
      pixels_in++;
      if (p.hue >= HueFullTurn) black_pixels++;
      if (p.saturation > 256 || p.brightness > 256) clamped_pixels++;
      rgb_pending_q.push_back(hsv_to_rgb_levels(p));
    endfunction

    function void check_result(input rgb_pixel_t got);
      rgb_pixel_t exp_px;
      results_seen++;
      if (rgb_pending_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Result %0d arrived with no pixel pending: r=%0d g=%0d b=%0d a=%0d",
                   results_seen, got.red, got.green, got.blue, got.alpha_out);
        return;
      end
      exp_px = rgb_pending_q.pop_front();
      if (got.red !== exp_px.red || got.green !== exp_px.green ||
          got.blue !== exp_px.blue || got.alpha_out !== exp_px.alpha_out) begin
        failures++;
        if (failures <= 10)
          $display("Mismatch %0d: exp r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                   results_seen, exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha_out,
                   got.red, got.green, got.blue, got.alpha_out);
      end
    endfunction

    function int unsigned pending();
      return rgb_pending_q.size();
    endfunction
  endclass

  localparam int unsigned NumRandom  = 550;
  localparam int unsigned QuietTail  = 80;
  localparam int unsigned StallLimit = 2000;

  logic       clk;
  logic       rst_n;
  logic       start;
  hsv_pixel_t pixel;
  logic       busy;
  logic       done;
  rgb_pixel_t result;

  pixel_checker pix_chk;
  int unsigned  stall_cycles;

  hsv_to_rgb_converter u_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .start_i  (start),
    .pixel_i  (pixel),
    .busy_o   (busy),
    .done_o   (done),
    .result_o (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      stall_cycles = stall_cycles + 1;
      if (start && !busy) begin
        pix_chk.note_pixel(pixel);
        stall_cycles = 0;
      end
      if (done) begin
        pix_chk.check_result(result);
        stall_cycles = 0;
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < StallLimit) @(posedge clk);
    $display("Timeout: no item or result moved for %0d cycles", StallLimit);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic hsv_pixel_t mk_pixel(input int unsigned h, input int unsigned s,
                                          input int unsigned v, input int unsigned a);
    hsv_pixel_t p;
    p.hue        = HueW'(h);
    p.saturation = LevelW'(s);
    p.brightness = LevelW'(v);
    p.alpha_in   = ByteW'(a);
    return p;
  endfunction

  task automatic drive_pixel(input hsv_pixel_t p);
    start <= 1'b1;
    pixel <= p;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic idle_sender(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pix_chk.pending() != 0) @(posedge clk);
  endtask

  function automatic hsv_pixel_t random_pixel();
    hsv_pixel_t  p;
    int unsigned edge_hue;
    case ($urandom_range(0, 9))
      0: p.hue = HueW'($urandom_range(23040, 32767));
      1: begin
        edge_hue = $urandom_range(0, 6) * 3840;
        p.hue    = (edge_hue == 0) ? HueW'($urandom_range(0, 1))
                                   : HueW'(edge_hue - 1 + $urandom_range(0, 2));
      end
      default: p.hue = HueW'($urandom_range(0, 23039));
    endcase
    p.saturation = ($urandom_range(0, 4) == 0) ? LevelW'($urandom_range(0, 511))
                                               : LevelW'($urandom_range(0, 256));
    p.brightness = ($urandom_range(0, 4) == 0) ? LevelW'($urandom_range(0, 511))
                                               : LevelW'($urandom_range(0, 256));
    p.alpha_in   = ByteW'($urandom_range(0, 255));
    return p;
  endfunction

  initial begin
    pix_chk = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    pixel   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_pixel(mk_pixel(0,     256, 256, 255));
    drive_pixel(mk_pixel(1920,  256, 256, 'hA5));
    drive_pixel(mk_pixel(3839,  256, 256, 'h5A));
    drive_pixel(mk_pixel(3840,  256, 256, 0));
    drive_pixel(mk_pixel(7679,  128, 200, 1));
    drive_pixel(mk_pixel(7680,  256, 256, 2));
    drive_pixel(mk_pixel(11519, 511, 256, 3));
    drive_pixel(mk_pixel(11520, 256, 256, 4));
    drive_pixel(mk_pixel(15359, 256, 511, 5));
    drive_pixel(mk_pixel(15360, 256, 256, 6));
    drive_pixel(mk_pixel(19199, 255, 255, 7));
    drive_pixel(mk_pixel(19200, 256, 256, 8));
    drive_pixel(mk_pixel(23039, 256, 256, 9));
    drive_pixel(mk_pixel(23040, 256, 256, 255));
    drive_pixel(mk_pixel(32767, 511, 511, 0));
    drive_pixel(mk_pixel(5000,  0,   256, 'h33));
    drive_pixel(mk_pixel(9000,  256, 0,   'hCC));
    drive_pixel(mk_pixel(13000, 511, 511, 'h0F));
    drive_pixel(mk_pixel(17000, 300, 200, 'hF0));
    drive_pixel(mk_pixel(21000, 1,   1,   'h80));
    drive_pixel(mk_pixel(2000,  511, 0,   'h7F));
    drive_pixel(mk_pixel(6000,  0,   511, 'hFE));

    for (int unsigned i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) drain_pipeline();
      if (i < NumRandom - QuietTail && $urandom_range(0, 3) == 0)
        idle_sender($urandom_range(1, 12));
      drive_pixel(random_pixel());
    end
    start <= 1'b0;

    while (pix_chk.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Converted %0d pixels and checked %0d results.",
             pix_chk.pixels_in, pix_chk.results_seen);
    $display("Among them %0d had hue past a full turn and %0d had levels above 1.0.",
             pix_chk.black_pixels, pix_chk.clamped_pixels);
    if (pix_chk.failures == 0 && pix_chk.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("Failures: %0d, results still missing: %0d",
               pix_chk.failures, pix_chk.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
